>>> rtl/hssc_pkg.sv
// Shared types, codes and reset constants for the heater schedule safety controller.
package hssc_pkg;

    localparam int MAX_STEPS_DEF     = 4;
    localparam int DURATION_BITS_DEF = 20;

    localparam int WORD_W     = 22;
    localparam int WORD_DUR_W = WORD_W - 2;
    localparam int REMAIN_W   = 20;
    localparam int CFG_DATA_W = 22;
    localparam int CFG_IDX_W  = 3;

    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_SET_MODE = 2'd1;
    localparam logic [1:0] OP_START    = 2'd2;
    localparam logic [1:0] OP_STOP     = 2'd3;

    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_WARM = 2'd1;
    localparam logic [1:0] MODE_LOW  = 2'd2;
    localparam logic [1:0] MODE_HIGH = 2'd3;

    localparam logic [1:0] ALERT_NONE   = 2'd0;
    localparam logic [1:0] ALERT_TEMP   = 2'd1;
    localparam logic [1:0] ALERT_SENSOR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SAFETY_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP0_WORD    = 3'd4;

    localparam int ERROR_LIMIT_RST = 10;
    localparam int SECONDS_PER_HOUR = 3600;

    localparam logic signed [15:0] SAFETY_LIMIT_RST = 16'sd3000;
    localparam logic [7:0]         ERR_LIMIT_RST    = 8'(ERROR_LIMIT_RST);
    localparam logic [2:0]         STEP_COUNT_RST   = 3'd3;
    localparam logic               REPEAT_RST       = 1'b0;
    localparam logic [7:0]         ERR_COUNT_MAX    = 8'hFF;

    localparam logic [3:0][WORD_W-1:0] STEP_WORD_RST = '{
        {WORD_DUR_W'(0), MODE_OFF},
        {WORD_DUR_W'(0), MODE_WARM},
        {WORD_DUR_W'(6 * SECONDS_PER_HOUR), MODE_LOW},
        {WORD_DUR_W'(SECONDS_PER_HOUR), MODE_HIGH}
    };

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] temperature;
        logic               reading_valid;
        logic [1:0]         requested_mode;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          mode;
        logic                main_on;
        logic                aux_on;
        logic signed [15:0]  last_temperature;
        logic                sensor_fault;
        logic [1:0]          alert;
        logic                schedule_running;
        logic [1:0]          current_step;
        logic [REMAIN_W-1:0] step_remaining;
    } t_out_item;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] temperature;
        logic               fault;
        logic [7:0]         error_count;
        logic               schedule_on;
        logic [1:0]         step_index;
    } t_ctl_state;

    typedef struct packed {
        logic signed [15:0] safety_limit;
        logic [7:0]         error_limit;
        logic [2:0]         step_count;
        logic               repeat_enable;
    } t_cfg;

endpackage

>>> rtl/heater_schedule_safety_controller.sv
// Top level of the heater schedule safety controller: registers, handshakes, config.
//
//  channel  dir  valid        stall        payload
//  in       in   i_in_valid   o_in_stall   i_in_data  (hssc_pkg::t_in_item)
//  out      out  o_out_valid  i_out_stall  o_out_data (hssc_pkg::t_out_item)
//  cfg      in   i_cfg_we     -            i_cfg_index, i_cfg_data
//
// An event passes from its input beat into the input register, then through the
// next-state logic into the result register.
// One event per cycle is sustained while the output is not stalled; the controller
// state updates when an event moves into the result register.
// Synchronous active-low reset clears state and both valids; config takes defaults.
// A stalled result holds the input register, which then stalls the input channel.
module heater_schedule_safety_controller #(
    parameter int MAX_STEPS     = hssc_pkg::MAX_STEPS_DEF,
    parameter int DURATION_BITS = hssc_pkg::DURATION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  hssc_pkg::t_in_item                  i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output hssc_pkg::t_out_item                 o_out_data,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_we,
    input  logic [hssc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hssc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic                                       r_in_valid;
    hssc_pkg::t_in_item                         r_in;
    logic                                       r_out_valid;
    hssc_pkg::t_out_item                        r_out;
    hssc_pkg::t_ctl_state                       r_state;
    hssc_pkg::t_ctl_state                       n_state;
    logic [DURATION_BITS-1:0]                   r_elapsed;
    logic [DURATION_BITS-1:0]                   n_elapsed;
    hssc_pkg::t_out_item                        n_out;
    hssc_pkg::t_cfg                             r_cfg;
    logic [MAX_STEPS-1:0][hssc_pkg::WORD_W-1:0] r_words;
    logic                                       advance;

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    hssc_step #(
        .MAX_STEPS     (MAX_STEPS),
        .DURATION_BITS (DURATION_BITS)
    ) u_step (
        .i_item    (r_in),
        .i_state   (r_state),
        .i_elapsed (r_elapsed),
        .i_cfg     (r_cfg),
        .i_words   (r_words),
        .o_state   (n_state),
        .o_elapsed (n_elapsed),
        .o_result  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= '0;
            r_elapsed <= '0;
        end else if (advance) begin
            r_state   <= n_state;
            r_elapsed <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.safety_limit  <= hssc_pkg::SAFETY_LIMIT_RST;
            r_cfg.error_limit   <= hssc_pkg::ERR_LIMIT_RST;
            r_cfg.step_count    <= hssc_pkg::STEP_COUNT_RST;
            r_cfg.repeat_enable <= hssc_pkg::REPEAT_RST;
            for (int k = 0; k < MAX_STEPS; k++) begin
                r_words[k] <= hssc_pkg::STEP_WORD_RST[k];
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hssc_pkg::CFG_SAFETY_LIMIT:  r_cfg.safety_limit  <= i_cfg_data[15:0];
                hssc_pkg::CFG_ERROR_LIMIT:   r_cfg.error_limit   <= i_cfg_data[7:0];
                hssc_pkg::CFG_STEP_COUNT:    r_cfg.step_count    <= i_cfg_data[2:0];
                hssc_pkg::CFG_REPEAT_ENABLE: r_cfg.repeat_enable <= i_cfg_data[0];
                default: begin
                    for (int k = 0; k < MAX_STEPS; k++) begin
                        if (i_cfg_index
                                == hssc_pkg::CFG_IDX_W'(hssc_pkg::CFG_STEP0_WORD + k)) begin
                            r_words[k] <= i_cfg_data[hssc_pkg::WORD_W-1:0];
                        end
                    end
                end
            endcase
        end
    end

    a_alert_shuts_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.alert != hssc_pkg::ALERT_NONE))
        |-> (o_out_data.mode == hssc_pkg::MODE_OFF) && !o_out_data.schedule_running)
        else $error("alert beat with heater still on or schedule running");

    a_remain_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.step_remaining != '0))
        |-> o_out_data.schedule_running)
        else $error("step time left reported without a running schedule");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("event moved forward but no result beat is pending");

    a_count_cleared_on_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in.operation == hssc_pkg::OP_TICK) && r_in.reading_valid)
        |=> (r_state.error_count == 8'd0) && !r_state.fault)
        else $error("good reading left an error count or fault behind");

endmodule

>>> rtl/hssc_step.sv
// Next-state and result logic for one event of the heater controller.
module hssc_step #(
    parameter int MAX_STEPS     = hssc_pkg::MAX_STEPS_DEF,
    parameter int DURATION_BITS = hssc_pkg::DURATION_BITS_DEF
) (
    input  hssc_pkg::t_in_item                           i_item,
    input  hssc_pkg::t_ctl_state                         i_state,
    input  logic [DURATION_BITS-1:0]                     i_elapsed,
    input  hssc_pkg::t_cfg                               i_cfg,
    input  logic [MAX_STEPS-1:0][hssc_pkg::WORD_W-1:0]   i_words,
    output hssc_pkg::t_ctl_state                         o_state,
    output logic [DURATION_BITS-1:0]                     o_elapsed,
    output hssc_pkg::t_out_item                          o_result
);

    localparam int REMAIN_W_L = hssc_pkg::REMAIN_W;

    function automatic logic [hssc_pkg::WORD_W-1:0] pick_word(
        input logic [MAX_STEPS-1:0][hssc_pkg::WORD_W-1:0] words,
        input logic [1:0] idx
    );
        logic [hssc_pkg::WORD_W-1:0] w;
        w = '0;
        for (int k = 0; k < MAX_STEPS; k++) begin
            if (idx == 2'(k)) begin
                w = words[k];
            end
        end
        return w;
    endfunction

    function automatic logic [DURATION_BITS-1:0] word_dur(
        input logic [hssc_pkg::WORD_W-1:0] w
    );
        return DURATION_BITS'(w[hssc_pkg::WORD_W-1:2]);
    endfunction

    function automatic logic [1:0] word_mode(
        input logic [hssc_pkg::WORD_W-1:0] w
    );
        return w[1:0];
    endfunction

    logic [2:0] active;
    assign active = (i_cfg.step_count > 3'(MAX_STEPS)) ? 3'(MAX_STEPS) : i_cfg.step_count;

    always_comb begin
        hssc_pkg::t_ctl_state       st;
        logic [DURATION_BITS-1:0]   el;
        logic [DURATION_BITS-1:0]   dur;
        logic [7:0]                 err_inc;
        logic [1:0]                 alert;
        logic                       heating;
        logic [REMAIN_W_L-1:0]      remain;

        st      = i_state;
        el      = i_elapsed;
        alert   = hssc_pkg::ALERT_NONE;
        remain  = '0;
        heating = i_state.mode != hssc_pkg::MODE_OFF;
        err_inc = '0;
        dur     = '0;

        case (i_item.operation)
            hssc_pkg::OP_TICK: begin
                if (i_item.reading_valid) begin
                    st.temperature = i_item.temperature;
                    st.fault       = 1'b0;
                    st.error_count = '0;
                end else begin
                    st.fault = 1'b1;
                end
                if (heating && i_item.reading_valid
                        && (i_item.temperature > i_cfg.safety_limit)) begin
                    st.mode        = hssc_pkg::MODE_OFF;
                    st.schedule_on = 1'b0;
                    alert          = hssc_pkg::ALERT_TEMP;
                end
                if (heating && !i_item.reading_valid) begin
                    err_inc = (st.error_count != hssc_pkg::ERR_COUNT_MAX)
                            ? st.error_count + 8'd1 : st.error_count;
                    if (err_inc > i_cfg.error_limit) begin
                        st.mode        = hssc_pkg::MODE_OFF;
                        st.schedule_on = 1'b0;
                        st.error_count = '0;
                        alert          = hssc_pkg::ALERT_SENSOR;
                    end else begin
                        st.error_count = err_inc;
                    end
                end
                if (st.schedule_on) begin
                    if (el != '1) begin
                        el = el + DURATION_BITS'(1);
                    end
                    dur = word_dur(pick_word(i_words, st.step_index));
                    if ((dur != '0) && (el >= dur)) begin
                        el = '0;
                        if ((3'({1'b0, st.step_index}) + 3'd1) >= active) begin
                            if (i_cfg.repeat_enable) begin
                                st.step_index = 2'd0;
                                st.mode       = word_mode(pick_word(i_words, 2'd0));
                            end else begin
                                st.schedule_on = 1'b0;
                            end
                        end else begin
                            st.step_index = st.step_index + 2'd1;
                            st.mode       = word_mode(pick_word(i_words, st.step_index));
                        end
                    end
                end
            end
            hssc_pkg::OP_SET_MODE: begin
                st.mode = i_item.requested_mode;
            end
            hssc_pkg::OP_START: begin
                if (active != 3'd0) begin
                    st.schedule_on = 1'b1;
                    st.step_index  = 2'd0;
                    el             = '0;
                    st.mode        = word_mode(pick_word(i_words, 2'd0));
                end
            end
            default: begin
                st.schedule_on = 1'b0;
            end
        endcase

        dur = word_dur(pick_word(i_words, st.step_index));
        if (st.schedule_on && (dur != '0) && (el < dur)) begin
            remain = REMAIN_W_L'(dur - el);
        end

        o_state   = st;
        o_elapsed = el;

        o_result.mode             = st.mode;
        o_result.main_on          = st.mode[1];
        o_result.aux_on           = st.mode[0];
        o_result.last_temperature = st.temperature;
        o_result.sensor_fault     = st.fault;
        o_result.alert            = alert;
        o_result.schedule_running = st.schedule_on;
        o_result.current_step     = st.step_index;
        o_result.step_remaining   = remain;
    end

endmodule
